// File: sv/sttam_pkg.sv
// shared types, constants and request structs for the stack arithmetic block
// no dependencies
package sttam_pkg;

    localparam int DATA_W          = 32;
    localparam int STEP_W          = $clog2(DATA_W);
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] push_value;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   stack_depth;
    } t_out_req;

    typedef struct packed {
        logic                load_item;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                push;
        logic                rd;
        logic                calc;
        logic                div_step;
        logic                commit;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_lt2;
        logic            count_full;
        logic            top_zero;
        logic            div_last;
    } t_dp_stat;

endpackage

// File: sv/sttam_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sttam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sttam_dpath.sv
// datapath: top register, entry count, stack ram, alu, serial divider, output register
// depends on sttam_pkg and sttam_ram
module sttam_dpath #(
    parameter int STACK_DEPTH = sttam_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sttam_pkg::t_in_req  i_in_data,
    input  sttam_pkg::t_dp_cmd  i_cmd,
    output sttam_pkg::t_dp_stat o_stat,
    output sttam_pkg::t_out_req o_out_data
);
    import sttam_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_top, n_top;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_status;
    logic [DATA_W-1:0]   r_res;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_quo;
    logic [DATA_W-1:0]   r_dvs;
    logic [STEP_W-1:0]   r_step;
    logic                r_neg_q;
    logic                r_neg_r;
    t_out_req            r_out;

    logic [DATA_W-1:0] w_second;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_mag_s;
    logic [DATA_W-1:0] w_mag_t;
    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_q_signed;
    logic [DATA_W-1:0] w_r_signed;
    logic [DATA_W-1:0] w_commit_val;
    logic [DATA_W-1:0] w_out_top;
    logic [CW+DEPTH_OUT_W-1:0] w_depth_ext;
    logic [2*DATA_W-1:0] w_prod;

    assign w_waddr = AW'(r_count - CW'(1));
    assign w_raddr = AW'(r_count - CW'(2));

    sttam_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push && (r_count != '0)),
        .i_waddr(w_waddr),
        .i_wdata(r_top),
        .i_re   (i_cmd.rd),
        .i_raddr(w_raddr),
        .o_rdata(w_second)
    );

    assign w_mag_s = w_second[DATA_W-1] ? (DATA_W'(0) - w_second) : w_second;
    assign w_mag_t = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
    assign w_prod  = w_second * r_top;

    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    assign w_q_signed = r_neg_q ? (DATA_W'(0) - r_quo) : r_quo;
    assign w_r_signed = r_neg_r ? (DATA_W'(0) - r_rem) : r_rem;

    always_comb begin
        unique case (r_op)
            OP_DIV:  w_commit_val = w_q_signed;
            OP_MOD:  w_commit_val = w_r_signed;
            default: w_commit_val = r_res;
        endcase
    end

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        if (i_cmd.push) begin
            n_top   = r_val;
            n_count = r_count + CW'(1);
        end else if (i_cmd.commit) begin
            n_top   = w_commit_val;
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (i_cmd.load_item) begin
            r_op  <= i_in_data.operation;
            r_val <= DATA_W'(i_in_data.push_value);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.calc) begin
            r_res   <= (r_op == OP_SUB) ? (w_second - r_top) : w_prod[DATA_W-1:0];
            r_rem   <= '0;
            r_quo   <= w_mag_s;
            r_dvs   <= w_mag_t;
            r_step  <= '0;
            r_neg_q <= w_second[DATA_W-1] ^ r_top[DATA_W-1];
            r_neg_r <= w_second[DATA_W-1];
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.top_value   <= $signed(w_out_top);
            r_out.stack_depth <= w_depth_ext[DEPTH_OUT_W-1:0];
        end
    end

    assign w_out_top   = (r_count == '0) ? '0 : r_top;
    assign w_depth_ext = {{DEPTH_OUT_W{1'b0}}, r_count};

    assign o_stat.op         = r_op;
    assign o_stat.count_lt2  = (r_count < CW'(2));
    assign o_stat.count_full = (r_count == CW'(STACK_DEPTH));
    assign o_stat.top_zero   = (r_top == '0);
    assign o_stat.div_last   = (r_step == STEP_W'(DATA_W - 1));

    assign o_out_data = r_out;

endmodule

// File: sv/sttam_ctrl.sv
// controller: sequences one request at a time through decode, read, execute, divide, commit and output
// depends on sttam_pkg
module sttam_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  sttam_pkg::t_dp_stat i_stat,
    output sttam_pkg::t_dp_cmd  o_cmd
);
    import sttam_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_READ   = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    t_dp_cmd  w_cmd;
    logic     w_arith;
    logic     w_divop;
    logic     w_out_free;

    assign w_divop    = (i_stat.op == OP_DIV) || (i_stat.op == OP_MOD);
    assign w_arith    = (i_stat.op == OP_SUB) || (i_stat.op == OP_MUL) || w_divop;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                w_cmd.set_status = 1'b1;
                w_cmd.status     = ST_OK;
                n_state          = S_DONE;
                priority if (i_stat.op == OP_PUSH) begin
                    if (i_stat.count_full) begin
                        w_cmd.status = ST_FULL;
                    end else begin
                        w_cmd.push = 1'b1;
                    end
                end else if (w_arith) begin
                    if (i_stat.count_lt2) begin
                        w_cmd.status = ST_SHORT;
                    end else if (w_divop && i_stat.top_zero) begin
                        w_cmd.status = ST_DIVZERO;
                    end else begin
                        w_cmd.rd = 1'b1;
                        n_state  = S_READ;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                w_cmd.calc = 1'b1;
                n_state    = w_divop ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                w_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// File: sv/stack_top_two_arithmetic.sv
// top level of the stack arithmetic machine: push, sub, mul, div, mod
// depends on sttam_pkg, sttam_ctrl, sttam_dpath (which holds sttam_ram)
//
//   channel  valid       stall        payload
//   in       i_in_valid  o_in_stall   i_in_data  (operation, push_value)
//   out      o_out_valid i_out_stall  o_out_data (status, top_value, stack_depth)
//
// per request: push, errors and undefined codes go from decode straight to output;
// sub and mul read, execute and commit; div and mod also run the one bit per cycle divider
// the result and o_out_valid are registered together once the output is free
// one request in flight; a new request is taken once the previous result is registered
// reset clears the entry count and control; the stack ram needs no clearing
// a stalled output holds the finished result and blocks the next request's completion
module stack_top_two_arithmetic #(
    parameter int STACK_DEPTH = sttam_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sttam_pkg::t_in_req  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sttam_pkg::t_out_req o_out_data
);
    import sttam_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sttam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sttam_dpath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_out_data(o_out_data)
    );

endmodule
